// File: src/deq_pkg.sv
// Shared types and codes for the double-ended queue core.
package deq_pkg;

    localparam int unsigned CMD_W   = 3;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned VALUE_W = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_DUMP       = 3'd4
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } state_t;

    typedef struct packed {
        logic [CMD_W-1:0]          command;
        logic signed [VALUE_W-1:0] value;
    } cmd_item_t;

    typedef struct packed {
        logic [STAT_W-1:0]         status;
        logic signed [VALUE_W-1:0] entry;
        logic                      last;
    } rsp_item_t;

endpackage

// File: src/double_ended_queue_core.sv
// Double-ended queue: circular store in a synchronous memory, results through a two-stage pipe.
// A push or pop result passes stage one, then the output register; a dump's first entry too.
// Throughput: one push or pop per cycle unless rsp_stall holds the pipe; a dump issues one read
// per held entry (none if empty) on the single read port; no command is taken until all are issued.
// Reset: indices, occupancy and all valid flags clear; the memory holds no reset value and
// only written entries are ever read.
module double_ended_queue_core #(
    parameter int unsigned DEPTH      = 64,
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  deq_pkg::cmd_item_t  cmd,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output deq_pkg::rsp_item_t  rsp
);
    import deq_pkg::*;

    localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam int unsigned EXT_W = 64;

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
        return (i == IDX_W'(DEPTH - 1)) ? '0 : i + IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_W'(DEPTH - 1) : i - IDX_W'(1);
    endfunction

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  front_reg, front_next;
    logic [IDX_W-1:0]  back_reg, back_next;
    logic [CNT_W-1:0]  occ_reg, occ_next;
    logic [IDX_W-1:0]  pos_reg, pos_next;
    logic [CNT_W-1:0]  left_reg, left_next;

    logic              s1_vld_reg;
    status_t           s1_status_reg, s1_status_next;
    logic              s1_last_reg, s1_last_next;
    logic              s1_mem_reg, s1_mem_next;
    logic              s1_load;

    logic              out_vld_reg;
    rsp_item_t         out_reg;

    logic              out_ready;
    logic              s1_free;
    logic              cmd_accept;
    logic              full;
    logic              empty;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [EXT_W-1:0]  value_ext;
    logic [EXT_W-1:0]  rd_ext;

    assign out_ready  = !out_vld_reg || !rsp_stall;
    assign s1_free    = !s1_vld_reg || out_ready;
    assign cmd_stall  = !((state_reg == S_IDLE) && s1_free);
    assign cmd_accept = cmd_valid && !cmd_stall;
    assign full       = (occ_reg == CNT_W'(DEPTH));
    assign empty      = (occ_reg == '0);
    assign value_ext  = {{(EXT_W - VALUE_W){1'b0}}, cmd.value};

    always_comb
    begin
        rd_ext = '0;
        rd_ext[DATA_WIDTH-1:0] = rd_data_reg;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_accept && (cmd.command == CMD_DUMP) && (occ_reg > CNT_W'(1)))
                begin
                    state_next = S_DUMP;
                end
            end
            S_DUMP:
            begin
                if (s1_free && (left_reg == CNT_W'(1)))
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath control
    always_comb
    begin
        wr_en          = 1'b0;
        wr_addr        = back_reg;
        rd_en          = 1'b0;
        rd_addr        = front_reg;
        front_next     = front_reg;
        back_next      = back_reg;
        occ_next       = occ_reg;
        pos_next       = pos_reg;
        left_next      = left_reg;
        s1_load        = 1'b0;
        s1_status_next = ST_OK;
        s1_last_next   = 1'b1;
        s1_mem_next    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_accept)
                begin
                    case (cmd.command) inside
                        CMD_PUSH_FRONT, CMD_PUSH_BACK:
                        begin
                            s1_load = 1'b1;
                            if (full)
                            begin
                                s1_status_next = ST_FULL;
                            end
                            else
                            begin
                                wr_en    = 1'b1;
                                occ_next = occ_reg + CNT_W'(1);
                                if (cmd.command == CMD_PUSH_FRONT)
                                begin
                                    wr_addr    = idx_dec(front_reg);
                                    front_next = idx_dec(front_reg);
                                end
                                else
                                begin
                                    wr_addr   = back_reg;
                                    back_next = idx_inc(back_reg);
                                end
                            end
                        end
                        CMD_POP_FRONT, CMD_POP_BACK:
                        begin
                            s1_load = 1'b1;
                            if (empty)
                            begin
                                s1_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                occ_next = occ_reg - CNT_W'(1);
                                if (cmd.command == CMD_POP_FRONT)
                                begin
                                    front_next = idx_inc(front_reg);
                                end
                                else
                                begin
                                    back_next = idx_dec(back_reg);
                                end
                            end
                        end
                        CMD_DUMP:
                        begin
                            s1_load = 1'b1;
                            if (empty)
                            begin
                                s1_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                rd_en        = 1'b1;
                                rd_addr      = front_reg;
                                s1_mem_next  = 1'b1;
                                s1_last_next = (occ_reg == CNT_W'(1));
                                pos_next     = idx_inc(front_reg);
                                left_next    = occ_reg - CNT_W'(1);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_DUMP:
            begin
                if (s1_free)
                begin
                    rd_en        = 1'b1;
                    rd_addr      = pos_reg;
                    s1_load      = 1'b1;
                    s1_mem_next  = 1'b1;
                    s1_last_next = (left_reg == CNT_W'(1));
                    pos_next     = idx_inc(pos_reg);
                    left_next    = left_reg - CNT_W'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= value_ext[DATA_WIDTH-1:0];
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            front_reg   <= '0;
            back_reg    <= '0;
            occ_reg     <= '0;
            pos_reg     <= '0;
            left_reg    <= '0;
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            front_reg <= front_next;
            back_reg  <= back_next;
            occ_reg   <= occ_next;
            pos_reg   <= pos_next;
            left_reg  <= left_next;
            if (s1_load)
            begin
                s1_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                s1_vld_reg <= 1'b0;
            end
            if (out_ready)
            begin
                out_vld_reg <= s1_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_status_reg <= s1_status_next;
            s1_last_reg   <= s1_last_next;
            s1_mem_reg    <= s1_mem_next;
        end
        if (out_ready && s1_vld_reg)
        begin
            out_reg.status <= s1_status_reg;
            out_reg.entry  <= s1_mem_reg ? rd_ext[VALUE_W-1:0] : '0;
            out_reg.last   <= s1_last_reg;
        end
    end

    assign rsp_valid = out_vld_reg;
    assign rsp       = out_reg;

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CNT_W'(DEPTH))
        else $error("occupancy above depth");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_accept && !full &&
         (cmd.command == CMD_PUSH_FRONT || cmd.command == CMD_PUSH_BACK))
        |=> (occ_reg == $past(occ_reg) + CNT_W'(1)))
        else $error("push did not grow occupancy");

    a_dump_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DUMP) |-> ($stable(occ_reg) && $stable(front_reg)))
        else $error("queue changed during dump");

    a_dump_block: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DUMP) |-> (cmd_stall && (left_reg != '0)))
        else $error("command taken or count lost during dump");

endmodule

// File: verif/double_ended_queue_core_test.sv
// Self-checking testbench for the double-ended queue core: directed and random command streams.
`timescale 1ns / 100ps

module double_ended_queue_core_test;

    import deq_pkg::*;

    localparam int unsigned Q_DEPTH       = 64;
    localparam int          CYCLE_LIMIT   = 3_000_000;
    localparam int          DRAIN_CYCLES  = 8;
    localparam logic [CMD_W-1:0] CMD_FIRST_UNUSED = 3'd5;
    localparam logic [CMD_W-1:0] CMD_LAST_UNUSED  = 3'd7;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      cmd_valid = 1'b0;
    logic      cmd_stall;
    cmd_item_t cmd       = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_item_t rsp;

    logic signed [VALUE_W-1:0] deq_store [Q_DEPTH];
    logic [5:0]                deq_front = '0;
    logic [5:0]                deq_back  = '0;
    logic [6:0]                deq_count = '0;
    rsp_item_t                 due_results [$];

    int error_count = 0;
    int cycle_count = 0;
    int stall_left  = 0;
    bit calm        = 1'b0;

    double_ended_queue_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        else if (r < 96)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic rsp_item_t make_result(status_t st, logic signed [VALUE_W-1:0] e,
                                              logic l);
        rsp_item_t r;
        r.status = st;
        r.entry  = e;
        r.last   = l;
        return r;
    endfunction

    function automatic void apply_command(cmd_item_t item);
        logic [5:0] pos;
        case (item.command)
            CMD_PUSH_FRONT, CMD_PUSH_BACK:
            begin
                if (deq_count >= Q_DEPTH)
                    due_results.push_back(make_result(ST_FULL, '0, 1'b1));
                else
                begin
                    if (item.command == CMD_PUSH_FRONT)
                    begin
                        deq_front            = deq_front - 6'd1;
                        deq_store[deq_front] = item.value;
                    end
                    else
                    begin
                        deq_store[deq_back] = item.value;
                        deq_back            = deq_back + 6'd1;
                    end
                    deq_count = deq_count + 7'd1;
                    due_results.push_back(make_result(ST_OK, '0, 1'b1));
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK:
            begin
                if (deq_count == 0)
                    due_results.push_back(make_result(ST_EMPTY, '0, 1'b1));
                else
                begin
                    if (item.command == CMD_POP_FRONT)
                        deq_front = deq_front + 6'd1;
                    else
                        deq_back = deq_back - 6'd1;
                    deq_count = deq_count - 7'd1;
                    due_results.push_back(make_result(ST_OK, '0, 1'b1));
                end
            end
            CMD_DUMP:
            begin
                if (deq_count == 0)
                    due_results.push_back(make_result(ST_EMPTY, '0, 1'b1));
                else
                begin
                    pos = deq_front;
                    for (int i = 0; i < deq_count; i++)
                    begin
                        due_results.push_back(make_result(ST_OK, deq_store[pos],
                                                          i == deq_count - 1));
                        pos = pos + 6'd1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic report_mismatch(string msg);
        $display("[cycle %0d] mismatch: %s", cycle_count, msg);
        error_count++;
    endtask

    task automatic check_result(rsp_item_t got);
        rsp_item_t want;
        if (due_results.size() == 0)
            report_mismatch($sformatf("result with nothing due: status %0d entry %0h last %0b",
                                      got.status, got.entry, got.last));
        else
        begin
            want = due_results.pop_front();
            if (got.status !== want.status)
                report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.entry !== want.entry)
                report_mismatch($sformatf("entry %0h, want %0h", got.entry, want.entry));
            if (got.last !== want.last)
                report_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            check_result(rsp);
    end

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            rsp_stall  <= 1'b1;
        end
        else if (!calm && $urandom_range(0, 99) < 20)
        begin
            stall_left <= pick_len() - 1;
            rsp_stall  <= 1'b1;
        end
        else
            rsp_stall <= 1'b0;
    end

    task automatic send_cmd(logic [CMD_W-1:0] code, logic signed [VALUE_W-1:0] value);
        cmd_item_t item;
        int        gap;
        item.command = code;
        item.value   = value;
        gap = (calm || $urandom_range(0, 99) < 60) ? 0 : pick_len();
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= item;
        do
            @(posedge clk);
        while (cmd_stall !== 1'b0);
        apply_command(item);
    endtask

    task automatic wait_drain();
        cmd_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [CMD_W-1:0] any_push();
        return $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
    endfunction

    function automatic logic [CMD_W-1:0] any_pop();
        return $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
    endfunction

    task automatic test_empty_queue();
        send_cmd(CMD_POP_FRONT, $urandom);
        send_cmd(CMD_POP_BACK, $urandom);
        send_cmd(CMD_DUMP, $urandom);
    endtask

    task automatic test_unused_codes();
        for (int c = int'(CMD_FIRST_UNUSED); c <= int'(CMD_LAST_UNUSED); c++)
            send_cmd(CMD_W'(c), $urandom);
    endtask

    task automatic test_both_ends();
        send_cmd(CMD_PUSH_FRONT, 32'sh7FFF_FFFF);
        send_cmd(CMD_PUSH_FRONT, 32'sh8000_0000);
        send_cmd(CMD_PUSH_BACK, '0);
        send_cmd(CMD_PUSH_BACK, '1);
        send_cmd(CMD_DUMP, $urandom);
        send_cmd(CMD_POP_FRONT, $urandom);
        send_cmd(CMD_POP_BACK, $urandom);
        send_cmd(CMD_DUMP, '1);
        send_cmd(CMD_POP_FRONT, '1);
        send_cmd(CMD_POP_BACK, '0);
        send_cmd(CMD_POP_BACK, $urandom);
    endtask

    task automatic test_single_entry();
        send_cmd(CMD_PUSH_BACK, $urandom);
        send_cmd(CMD_DUMP, $urandom);
        send_cmd(CMD_POP_BACK, $urandom);
        send_cmd(CMD_DUMP, $urandom);
    endtask

    task automatic test_full_queue();
        while (deq_count < Q_DEPTH)
            send_cmd(any_push(), $urandom);
        repeat (4) send_cmd(any_push(), $urandom);
        send_cmd(CMD_DUMP, $urandom);
        repeat (20) send_cmd(any_pop(), $urandom);
    endtask

    task automatic test_random_mix(int n);
        int               sent;
        int               r;
        bit               filling;
        logic [CMD_W-1:0] code;
        sent    = 0;
        filling = 1'b1;
        while (sent < n)
        begin
            if (deq_count == Q_DEPTH)
                filling = 1'b0;
            else if (deq_count == 0)
                filling = 1'b1;
            else if ($urandom_range(0, 99) < 4)
                filling = !filling;
            r = $urandom_range(0, 99);
            if (r < 4)
                code = CMD_W'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_UNUSED));
            else if (r < 12)
                code = CMD_DUMP;
            else if (r < 80)
                code = filling ? any_push() : any_pop();
            else
                code = filling ? any_pop() : any_push();
            send_cmd(code, $urandom);
            if (code <= CMD_DUMP)
                sent++;
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_empty_queue();
        wait_drain();
        test_unused_codes();
        wait_drain();
        test_both_ends();
        wait_drain();
        test_single_entry();
        wait_drain();
        test_full_queue();
        wait_drain();
        calm = 1'b1;
        test_random_mix(30);
        wait_drain();
        calm = 1'b0;
        test_random_mix(40);
        wait_drain();

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
